// ===== hw/rtl/piofit_pkg.sv =====
// Package for the pairwise image overlap fitness block.
// Holds field widths, limits and saturation constants.
// Depends on nothing; used by pairwise_image_overlap_fitness.
`timescale 1ns / 1ps

package piofit_pkg;

	// Field widths of the input and result transactions.
	localparam int POS_W   = 24;
	localparam int SCALE_W = 24;
	localparam int FIT_W   = 48;
	localparam int TALLY_W = 16;

	// Widths of the per-source and per-set accumulators.
	localparam int CNT_W = 8;
	localparam int SUM_W = 32;
	localparam int SQ_W  = 56;
	localparam int ACC_W = 64;

	// Shared multiplier operand width and divider widths.
	localparam int MUL_W = 32;
	localparam int DVS_W = 16;

	// Limits on images per source and counted sources.
	localparam logic [CNT_W-1:0]   MAX_IMAGES  = 8'd255;
	localparam logic [TALLY_W-1:0] MAX_SOURCES = 16'hFFFF;

	// Saturation value of a source's scaled fitness.
	localparam logic [FIT_W-1:0] FIT_MAX = {FIT_W{1'b1}};

endpackage

// ===== hw/rtl/pairwise_image_overlap_fitness.sv =====
// Pairwise image overlap fitness: one item per image, one result per set.
// An image passes the squaring, accumulate and check states before ready returns. A source
// end with two or more images adds the pair-sum steps, the bit-serial divider and the
// scaling multiply. A set end adds a pass through the 64-step divider, skipped when no source
// counted, plus the wait for the output register to be free. A new image waits until the last is through.
// Reset (arst_n low, asynchronous) clears all sums and counts and drops the output valid.
`timescale 1ns / 1ps

module pairwise_image_overlap_fitness (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // pos_x[23:0], pos_y[47:24], src_scale[71:48]
	input  logic        s_axis_tlast,  // last_of_source
	input  logic        s_axis_tuser,  // last_of_set
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // fitness[47:0], sources_used[63:48]
);

	// Sequencer states.
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SQX  = 5'd1;
	localparam logic [4:0] S_SQY  = 5'd2;
	localparam logic [4:0] S_ACC  = 5'd3;
	localparam logic [4:0] S_CHK  = 5'd4;
	localparam logic [4:0] S_N0   = 5'd5;
	localparam logic [4:0] S_N1   = 5'd6;
	localparam logic [4:0] S_SX   = 5'd7;
	localparam logic [4:0] S_SY   = 5'd8;
	localparam logic [4:0] S_PR   = 5'd9;
	localparam logic [4:0] S_DVS  = 5'd10;
	localparam logic [4:0] S_DIV  = 5'd11;
	localparam logic [4:0] S_M0   = 5'd12;
	localparam logic [4:0] S_M1   = 5'd13;
	localparam logic [4:0] S_M2   = 5'd14;
	localparam logic [4:0] S_ADD  = 5'd15;
	localparam logic [4:0] S_FSET = 5'd16;
	localparam logic [4:0] S_OUT  = 5'd17;

	localparam int POS_W   = piofit_pkg::POS_W;
	localparam int SCALE_W = piofit_pkg::SCALE_W;
	localparam int FIT_W   = piofit_pkg::FIT_W;
	localparam int TALLY_W = piofit_pkg::TALLY_W;
	localparam int CNT_W   = piofit_pkg::CNT_W;
	localparam int SUM_W   = piofit_pkg::SUM_W;
	localparam int SQ_W    = piofit_pkg::SQ_W;
	localparam int ACC_W   = piofit_pkg::ACC_W;
	localparam int MUL_W   = piofit_pkg::MUL_W;
	localparam int DVS_W   = piofit_pkg::DVS_W;

	logic [4:0] state_q;

	// Latched input transaction.
	logic [POS_W-1:0]   x_q;
	logic [POS_W-1:0]   y_q;
	logic [SCALE_W-1:0] scale_q;
	logic               end_src_q;
	logic               end_set_q;

	// Per-source and per-set state.
	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_x_q;
	logic signed [SUM_W-1:0] sum_y_q;
	logic [SQ_W-1:0]         sum_sq_q;
	logic [ACC_W-1:0]        acc_q;
	logic [TALLY_W-1:0]      tally_q;

	// Working registers of the source close.
	logic [ACC_W-1:0] tot_q;
	logic [73:0]      val_q;

	// Shared multiplier.
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [2*MUL_W-1:0] prod_c;
	logic [2*MUL_W-1:0] prod_q;

	// Shared bit-serial divider: dq_q holds dividend bits and collects quotient bits.
	logic [ACC_W-1:0] dq_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [5:0]       dcnt_q;
	logic             dfin_q;
	logic [DVS_W:0]   rem_sh;
	logic             rem_ge;
	logic [DVS_W:0]   rem_sub;
	logic [DVS_W-1:0] rem_nxt;

	// Output register.
	logic               m_valid_q;
	logic [FIT_W-1:0]   out_fit_q;
	logic [TALLY_W-1:0] out_used_q;

	// Magnitudes used as multiplier operands.
	logic [POS_W-1:0] abs_x;
	logic [POS_W-1:0] abs_y;
	logic [SUM_W-1:0] abs_sx;
	logic [SUM_W-1:0] abs_sy;
	logic [FIT_W-1:0] val_sat;
	logic             src_counts;

	assign abs_x  = x_q[POS_W-1] ? (~x_q + 1'b1) : x_q;
	assign abs_y  = y_q[POS_W-1] ? (~y_q + 1'b1) : y_q;
	assign abs_sx = sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
	assign abs_sy = sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);

	// A source is counted when it has two or more images and the tally has room.
	assign src_counts = (count_q >= CNT_W'(2)) && (tally_q < piofit_pkg::MAX_SOURCES);

	// Scaled value after the Q8.16 shift, saturated at the output maximum.
	assign val_sat = (val_q[73:64] != 10'd0) ? piofit_pkg::FIT_MAX : val_q[63:16];

	// Multiplier operand selection by sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQX: begin
				mul_a = MUL_W'(abs_x);
				mul_b = MUL_W'(abs_x);
			end
			S_SQY: begin
				mul_a = MUL_W'(abs_y);
				mul_b = MUL_W'(abs_y);
			end
			S_N0: begin
				mul_a = sum_sq_q[31:0];
				mul_b = MUL_W'(count_q);
			end
			S_N1: begin
				mul_a = MUL_W'(sum_sq_q[SQ_W-1:32]);
				mul_b = MUL_W'(count_q);
			end
			S_SX: begin
				mul_a = abs_sx;
				mul_b = abs_sx;
			end
			S_SY: begin
				mul_a = abs_sy;
				mul_b = abs_sy;
			end
			S_PR: begin
				mul_a = MUL_W'(count_q);
				mul_b = MUL_W'(count_q - CNT_W'(1));
			end
			S_M0: begin
				mul_a = dq_q[31:0];
				mul_b = MUL_W'(scale_q);
			end
			S_M1: begin
				mul_a = MUL_W'(dq_q[49:32]);
				mul_b = MUL_W'(scale_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_c = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

	always_ff @(posedge clk) begin
		prod_q <= prod_c;
	end

	// One restoring division step.
	assign rem_sh  = {rem_q, dq_q[ACC_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign rem_nxt = rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			sum_x_q    <= '0;
			sum_y_q    <= '0;
			sum_sq_q   <= '0;
			acc_q      <= '0;
			tally_q    <= '0;
			dfin_q     <= 1'b0;
			dcnt_q     <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			// The output step loads the next result itself.
			if (m_valid_q && m_axis_tready && state_q != S_OUT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						if (count_q < piofit_pkg::MAX_IMAGES) begin
							state_q <= S_SQX;
						end else begin
							state_q <= S_CHK;
						end
					end
				end
				S_SQX: begin
					state_q <= S_SQY;
				end
				S_SQY: begin
					sum_sq_q <= sum_sq_q + SQ_W'(prod_q);
					state_q  <= S_ACC;
				end
				S_ACC: begin
					sum_sq_q <= sum_sq_q + SQ_W'(prod_q);
					sum_x_q  <= sum_x_q + SUM_W'(signed'(x_q));
					sum_y_q  <= sum_y_q + SUM_W'(signed'(y_q));
					count_q  <= count_q + CNT_W'(1);
					state_q  <= S_CHK;
				end
				S_CHK: begin
					if (end_src_q || end_set_q) begin
						if (src_counts) begin
							state_q <= S_N0;
						end else begin
							count_q  <= '0;
							sum_x_q  <= '0;
							sum_y_q  <= '0;
							sum_sq_q <= '0;
							state_q  <= end_set_q ? S_FSET : S_IDLE;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_N0: begin
					state_q <= S_N1;
				end
				S_N1: begin
					state_q <= S_SX;
				end
				S_SX: begin
					state_q <= S_SY;
				end
				S_SY: begin
					state_q <= S_PR;
				end
				S_PR: begin
					state_q <= S_DVS;
				end
				S_DVS: begin
					dcnt_q  <= '0;
					dfin_q  <= 1'b0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd63) begin
						state_q <= dfin_q ? S_OUT : S_M0;
					end
				end
				S_M0: begin
					state_q <= S_M1;
				end
				S_M1: begin
					state_q <= S_M2;
				end
				S_M2: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					// The sum of at most 65535 saturated values fits in the accumulator.
					acc_q    <= acc_q + ACC_W'(val_sat);
					tally_q  <= tally_q + TALLY_W'(1);
					count_q  <= '0;
					sum_x_q  <= '0;
					sum_y_q  <= '0;
					sum_sq_q <= '0;
					state_q  <= end_set_q ? S_FSET : S_IDLE;
				end
				S_FSET: begin
					dcnt_q <= '0;
					dfin_q <= 1'b1;
					if (tally_q == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						acc_q     <= '0;
						tally_q   <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the input, pair sum, divider, scaled value and output.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			x_q       <= s_axis_tdata[23:0];
			y_q       <= s_axis_tdata[47:24];
			scale_q   <= s_axis_tdata[71:48];
			end_src_q <= s_axis_tlast;
			end_set_q <= s_axis_tuser;
		end
		case (state_q)
			S_N1: begin
				tot_q <= prod_q;
			end
			S_SX: begin
				tot_q <= tot_q + {prod_q[31:0], 32'd0};
			end
			S_SY: begin
				tot_q <= tot_q - prod_q;
			end
			S_PR: begin
				tot_q <= tot_q - prod_q;
			end
			S_DVS: begin
				// Divide the pair sum by n*(n-1)/2.
				dq_q  <= tot_q;
				dvs_q <= prod_q[DVS_W:1];
				rem_q <= '0;
			end
			S_DIV: begin
				dq_q  <= {dq_q[ACC_W-2:0], rem_ge};
				rem_q <= rem_nxt;
			end
			S_M1: begin
				val_q <= {18'd0, prod_q[55:0]};
			end
			S_M2: begin
				val_q <= val_q + {prod_q[41:0], 32'd0};
			end
			S_FSET: begin
				// Mean over counted sources, or zero when none counted.
				dq_q  <= (tally_q == '0) ? '0 : acc_q;
				dvs_q <= tally_q;
				rem_q <= '0;
			end
			S_OUT: begin
				if (!m_valid_q || m_axis_tready) begin
					out_fit_q  <= dq_q[FIT_W-1:0];
					out_used_q <= tally_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {out_used_q, out_fit_q};

endmodule
